### rtl/core/tht_pkg.sv
// Shared types and codes of the TCP handshake flow tracker.
// Used by the slot cell, the top level and the port checker; depends on nothing.
package tht_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_SEGMENT  = 2'd0;
  localparam logic [1:0] OP_REGISTER = 2'd1;
  localparam logic [1:0] OP_CANCEL   = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_WATCH  = 2'd0;
  localparam logic [1:0] KIND_OK     = 2'd1;
  localparam logic [1:0] KIND_FAIL   = 2'd2;
  localparam logic [1:0] KIND_INJECT = 2'd3;

  // Failure causes.
  localparam logic [3:0] FR_TOO_BIG          = 4'd0;
  localparam logic [3:0] FR_RST_PRE_SYNACK   = 4'd1;
  localparam logic [3:0] FR_RST_PRE_SYNACK2  = 4'd2;
  localparam logic [3:0] FR_RST_PRE_ACK      = 4'd3;
  localparam logic [3:0] FR_OUT_AFTER_FAKE   = 4'd4;
  localparam logic [3:0] FR_NO_SYN           = 4'd5;
  localparam logic [3:0] FR_ACK_MISMATCH     = 4'd6;
  localparam logic [3:0] FR_SEQ_CHANGE       = 4'd7;
  localparam logic [3:0] FR_RST_GOT          = 4'd8;
  localparam logic [3:0] FR_UNEXP_IN         = 4'd9;
  localparam logic [3:0] FR_RST_GOT2         = 4'd10;
  localparam logic [3:0] FR_RST_AFTER_FAKE   = 4'd11;
  localparam logic [3:0] FR_UNEXP_AFTER_FAKE = 4'd12;
  localparam logic [3:0] FR_TIMEOUT          = 4'd13;
  localparam logic [3:0] FR_BAD_FAKE         = 4'd14;
  localparam logic [3:0] FR_BUSY             = 4'd15;

  // Handshake phases of a slot.
  localparam logic [2:0] PH_WANT_SYN    = 3'd0;
  localparam logic [2:0] PH_WANT_SYNACK = 3'd1;
  localparam logic [2:0] PH_WANT_ACK    = 3'd2;
  localparam logic [2:0] PH_FAKE_SENT   = 3'd3;
  localparam logic [2:0] PH_DONE        = 3'd4;

  // TCP flag bit positions.
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

  localparam logic [13:0] FAKE_MAX_BYTES  = 14'd8192;
  localparam logic [6:0]  MAX_RESULTS     = 7'd64;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd8000;
  localparam logic [9:0]  PKT_LIMIT_RESET = 10'd512;

  // Which one-hot selection the cells use for reads and writes.
  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_HIT,
    SEL_FREE_DONE,
    SEL_FREE,
    SEL_EXPIRED
  } sel_t;

  // Item fields broadcast to every cell.
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] id;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [13:0] fake;
    logic [31:0] now1;
  } bcast_t;

  // Update of the selected cell.
  typedef struct packed {
    logic        we;
    logic        enroll;
    logic        kill;
    logic        set_phase;
    logic [2:0]  phase;
    logic        set_syn;
    logic        set_synack;
    logic [31:0] deadline;
  } cell_wr_t;

  // Priority carries passed from cell to cell.
  typedef struct packed {
    logic hit;
    logic fd;
    logic fr;
    logic exp1;
    logic exp2;
  } chain_t;

  // Contents of the selected cell, OR-collected along the row.
  typedef struct packed {
    logic [15:0] tag;
    logic [2:0]  phase;
    logic [13:0] fake;
    logic [31:0] syn;
    logic [31:0] synack;
    logic        fwd;
  } cell_rd_t;

endpackage

### rtl/core/tht_cell.sv
// One flow slot of the tracker: its state, match and expiry checks, and its
// link in the priority and read chains. Depends on tht_pkg.
module tht_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  tht_pkg::bcast_t   bc,
  input  logic              chk,
  input  logic              pick,
  input  tht_pkg::sel_t     code,
  input  tht_pkg::cell_wr_t wr,
  input  tht_pkg::chain_t   cin,
  output tht_pkg::chain_t   cout,
  input  tht_pkg::cell_rd_t rin,
  output tht_pkg::cell_rd_t rout
);

  logic        active_r;
  logic [2:0]  phase_r;
  logic [15:0] tag_r;
  logic [31:0] lip_r;
  logic [31:0] rip_r;
  logic [15:0] lport_r;
  logic [15:0] rport_r;
  logic [13:0] fake_r;
  logic [31:0] syn_r;
  logic [31:0] synack_r;
  logic [31:0] dl_r;
  logic        hit_r, fwd_r, fd_r, fr_r, exp_r;
  logic        shit_r, sfd_r, sfr_r;
  logic        fwd_m, rev_m, expd, sel;
  logic [31:0] diff;

  assign fwd_m = active_r && lip_r == bc.sip && lport_r == bc.sport &&
                 rip_r == bc.dip && rport_r == bc.dport;
  assign rev_m = active_r && rip_r == bc.sip && rport_r == bc.sport &&
                 lip_r == bc.dip && lport_r == bc.dport;
  assign diff  = bc.now1 - dl_r;
  assign expd  = active_r && diff != 32'd0 && !diff[31];

  always_comb begin
    unique case (code)
      tht_pkg::SEL_HIT:       sel = shit_r;
      tht_pkg::SEL_FREE_DONE: sel = sfd_r;
      tht_pkg::SEL_FREE:      sel = sfr_r;
      tht_pkg::SEL_EXPIRED:   sel = exp_r && !cin.exp1;
      default:                sel = 1'b0;
    endcase
  end

  assign cout.hit  = cin.hit | hit_r;
  assign cout.fd   = cin.fd | fd_r;
  assign cout.fr   = cin.fr | fr_r;
  assign cout.exp1 = cin.exp1 | exp_r;
  assign cout.exp2 = cin.exp2 | (cin.exp1 & exp_r);

  assign rout.tag    = rin.tag | (sel ? tag_r : 16'd0);
  assign rout.phase  = rin.phase | (sel ? phase_r : 3'd0);
  assign rout.fake   = rin.fake | (sel ? fake_r : 14'd0);
  assign rout.syn    = rin.syn | (sel ? syn_r : 32'd0);
  assign rout.synack = rin.synack | (sel ? synack_r : 32'd0);
  assign rout.fwd    = rin.fwd | (sel & fwd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= tht_pkg::PH_WANT_SYN;
      hit_r    <= 1'b0;
      fwd_r    <= 1'b0;
      fd_r     <= 1'b0;
      fr_r     <= 1'b0;
      exp_r    <= 1'b0;
      shit_r   <= 1'b0;
      sfd_r    <= 1'b0;
      sfr_r    <= 1'b0;
    end else begin
      if (chk) begin
        hit_r <= fwd_m | rev_m;
        fwd_r <= fwd_m;
        fd_r  <= !active_r && phase_r == tht_pkg::PH_DONE;
        fr_r  <= !active_r;
        exp_r <= bc.op == tht_pkg::OP_TICK && expd;
        if (bc.op == tht_pkg::OP_CANCEL && active_r && tag_r == bc.id) begin
          active_r <= 1'b0;
          phase_r  <= tht_pkg::PH_DONE;
        end
      end
      if (pick) begin
        shit_r <= hit_r & !cin.hit;
        sfd_r  <= fd_r & !cin.fd;
        sfr_r  <= fr_r & !cin.fr;
      end
      if (wr.we && sel) begin
        if (wr.enroll) begin
          active_r <= 1'b1;
          phase_r  <= tht_pkg::PH_WANT_SYN;
          tag_r    <= bc.id;
          lip_r    <= bc.sip;
          rip_r    <= bc.dip;
          lport_r  <= bc.sport;
          rport_r  <= bc.dport;
          fake_r   <= bc.fake;
          syn_r    <= 32'd0;
          synack_r <= 32'd0;
          dl_r     <= wr.deadline;
        end else begin
          if (wr.set_phase) phase_r <= wr.phase;
          if (wr.set_syn) syn_r <= bc.seq;
          if (wr.set_synack) synack_r <= bc.seq;
          if (wr.kill) begin
            active_r <= 1'b0;
            phase_r  <= tht_pkg::PH_DONE;
            exp_r    <= 1'b0;
          end
        end
      end
    end
  end

endmodule

### rtl/core/tcp_handshake_flow_tracker.sv
// Top level of the TCP handshake flow tracker: stream ports, register port,
// sequencer and the row of tht_cell slots. Depends on tht_pkg and tht_cell.
// Steps: a segment or registration passes the check, priority pick, read and
// decide states; the result is registered in the decide state and the input is
// then free again. A registration with a bad fake length answers from its own
// state. A cancel frees the input after the check state. A tick's timeouts come
// from the expiry state after the check, one a cycle unless the output stalls (at
// most 64), freeing the input after the last. Result stalls hold the result states; one item at a time.
// Reset is synchronous and active low; it frees every slot and restores the
// register defaults.
module tcp_handshake_flow_tracker #(
  parameter int FLOW_SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata, lowest bit up: flow_id 16, src_ip 32, dst_ip 32, source port 16,
  // destination port 16, seq_num 32, ack_num 32, tcp_flags 6, payload_bytes 16,
  // header_bytes 7, fake_bytes 14, zero fill 5.
  input  logic [223:0] in_tdata,
  // tuser: op 2.
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata, lowest bit up: result_id 16, fail_reason 4, inject_seq 32, zero fill 4.
  output logic [55:0]  out_tdata,
  // tuser: kind 2.
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_PICK, S_READ, S_DEC, S_EXP, S_BAD
  } state_t;

  state_t            state_r;
  logic [15:0]       timeout_r;
  logic [9:0]        limit_r;
  logic [31:0]       now_r;
  logic [1:0]        op_r;
  logic [15:0]       id_r;
  logic [31:0]       sip_r, dip_r, seq_r, ack_r;
  logic [15:0]       sport_r, dport_r, plen_r;
  logic [5:0]        flags_r;
  logic [6:0]        hdr_r;
  logic [13:0]       fake_r;
  tht_pkg::sel_t     code_r;
  tht_pkg::cell_rd_t rd_r;
  logic [6:0]        cnt_r;
  logic              out_valid_r, out_last_r;
  logic [1:0]        out_kind_r;
  logic [15:0]       out_id_r;
  logic [3:0]        out_reason_r;
  logic [31:0]       out_seq_r;

  tht_pkg::bcast_t   bc;
  tht_pkg::cell_wr_t wr;
  tht_pkg::chain_t   chain [FLOW_SLOTS+1];
  tht_pkg::cell_rd_t rdc   [FLOW_SLOTS+1];
  tht_pkg::chain_t   tail;
  tht_pkg::cell_rd_t rd_tail;

  logic accept, out_free, bad_fake, out_load;

  // Register port: paddr bit 2 picks the register, pready is tied high.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {22'd0, limit_r} : {16'd0, timeout_r};

  assign in_tready = state_r == S_IDLE;
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign bad_fake  = in_tdata[218:205] == 14'd0 || in_tdata[218:205] > tht_pkg::FAKE_MAX_BYTES;

  // The output register is loaded in this cycle by one of the result states.
  assign out_load  = out_free && (state_r == S_BAD || state_r == S_DEC ||
                     (state_r == S_EXP && tail.exp1 && cnt_r != tht_pkg::MAX_RESULTS));

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_seq_r, out_reason_r, out_id_r};

  assign bc.op    = op_r;
  assign bc.id    = id_r;
  assign bc.sip   = sip_r;
  assign bc.dip   = dip_r;
  assign bc.sport = sport_r;
  assign bc.dport = dport_r;
  assign bc.seq   = seq_r;
  assign bc.fake  = fake_r;
  assign bc.now1  = now_r + 32'd1;

  // The row of slots: each cell passes the priority carries and the read
  // data of the selected slot on to its neighbour, so the first slot that
  // qualifies wins.
  assign chain[0] = '0;
  assign rdc[0]   = '0;
  for (genvar k = 0; k < FLOW_SLOTS; k++) begin : g_slot
    tht_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .bc   (bc),
      .chk  (state_r == S_CHK),
      .pick (state_r == S_PICK),
      .code (code_r),
      .wr   (wr),
      .cin  (chain[k]),
      .cout (chain[k+1]),
      .rin  (rdc[k]),
      .rout (rdc[k+1])
    );
  end
  assign tail    = chain[FLOW_SLOTS];
  assign rd_tail = rdc[FLOW_SLOTS];

  // Decision on the slot that was read: handshake machine of the flow.
  logic        dec_emit, dec_kill, dec_set_phase, dec_set_syn, dec_set_synack;
  logic [2:0]  dec_phase;
  logic [1:0]  dec_kind;
  logic [3:0]  dec_reason;
  logic [31:0] dec_seq;
  logic        rst_f, pure_ack, bare_syn, syn_ack;
  logic [31:0] syn1, synack1;
  logic [14:0] pkt_len;

  assign rst_f    = flags_r[tht_pkg::FLAG_RST];
  assign pure_ack = flags_r[tht_pkg::FLAG_ACK] && !flags_r[tht_pkg::FLAG_SYN] && !rst_f &&
                    plen_r == 16'd0;
  assign bare_syn = !flags_r[tht_pkg::FLAG_ACK] && flags_r[tht_pkg::FLAG_SYN] &&
                    plen_r == 16'd0 && ack_r == 32'd0;
  assign syn_ack  = flags_r[tht_pkg::FLAG_ACK] && flags_r[tht_pkg::FLAG_SYN] && plen_r == 16'd0;
  assign syn1     = rd_r.syn + 32'd1;
  assign synack1  = rd_r.synack + 32'd1;
  assign pkt_len  = {8'd0, hdr_r} + {1'b0, rd_r.fake};

  always_comb begin
    dec_emit       = 1'b0;
    dec_kill       = 1'b0;
    dec_set_phase  = 1'b0;
    dec_phase      = tht_pkg::PH_WANT_SYN;
    dec_set_syn    = 1'b0;
    dec_set_synack = 1'b0;
    dec_kind       = tht_pkg::KIND_FAIL;
    dec_reason     = tht_pkg::FR_TOO_BIG;
    dec_seq        = 32'd0;
    if (rd_r.fwd) begin
      unique case (rd_r.phase)
        tht_pkg::PH_WANT_SYN: begin
          if (bare_syn) begin
            dec_set_syn   = 1'b1;
            dec_set_phase = 1'b1;
            dec_phase     = tht_pkg::PH_WANT_SYNACK;
          end else if (rst_f) begin
            dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_RST_PRE_SYNACK;
          end
        end
        tht_pkg::PH_WANT_SYNACK: begin
          if (!(bare_syn && seq_r == rd_r.syn) && rst_f) begin
            dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_RST_PRE_SYNACK2;
          end
        end
        tht_pkg::PH_WANT_ACK: begin
          if (pure_ack && seq_r == syn1 && ack_r == synack1) begin
            dec_emit = 1'b1;
            if (pkt_len > {5'd0, limit_r}) begin
              dec_kill   = 1'b1;
              dec_reason = tht_pkg::FR_TOO_BIG;
            end else begin
              dec_set_phase = 1'b1;
              dec_phase     = tht_pkg::PH_FAKE_SENT;
              dec_kind      = tht_pkg::KIND_INJECT;
              dec_seq       = syn1 - {18'd0, rd_r.fake};
            end
          end else if (rst_f) begin
            dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_RST_PRE_ACK;
          end
        end
        tht_pkg::PH_FAKE_SENT: begin
          if (plen_r != 16'd0) begin
            dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_OUT_AFTER_FAKE;
          end
        end
        default: ;
      endcase
    end else begin
      unique case (rd_r.phase)
        tht_pkg::PH_WANT_SYN: begin
          dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_NO_SYN;
        end
        tht_pkg::PH_WANT_SYNACK: begin
          priority if (syn_ack) begin
            priority if (ack_r != syn1) begin
              dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_ACK_MISMATCH;
            end else if (rd_r.synack != 32'd0 && rd_r.synack != seq_r) begin
              // Kept although the phase order never lets it happen.
              dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_SEQ_CHANGE;
            end else begin
              dec_set_synack = 1'b1;
              dec_set_phase  = 1'b1;
              dec_phase      = tht_pkg::PH_WANT_ACK;
            end
          end else if (rst_f) begin
            dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_RST_GOT;
          end else begin
            dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_UNEXP_IN;
          end
        end
        tht_pkg::PH_WANT_ACK: begin
          if (rst_f) begin
            dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_RST_GOT2;
          end
        end
        tht_pkg::PH_FAKE_SENT: begin
          if (pure_ack && seq_r == synack1 && ack_r == syn1) begin
            dec_emit = 1'b1; dec_kill = 1'b1; dec_kind = tht_pkg::KIND_OK;
            dec_reason = tht_pkg::FR_TOO_BIG;
          end else if (rst_f) begin
            dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_RST_AFTER_FAKE;
          end else if (plen_r != 16'd0) begin
            dec_emit = 1'b1; dec_kill = 1'b1; dec_reason = tht_pkg::FR_UNEXP_AFTER_FAKE;
          end
        end
        default: ;
      endcase
    end
  end

  // Cell write of the current state.
  always_comb begin
    wr           = '0;
    wr.deadline  = now_r + {16'd0, timeout_r};
    if (state_r == S_DEC && out_free && code_r != tht_pkg::SEL_NONE) begin
      wr.we = 1'b1;
      if (op_r == tht_pkg::OP_REGISTER) begin
        wr.enroll = 1'b1;
      end else begin
        wr.kill       = dec_kill;
        wr.set_phase  = dec_set_phase;
        wr.phase      = dec_phase;
        wr.set_syn    = dec_set_syn;
        wr.set_synack = dec_set_synack;
      end
    end else if (state_r == S_EXP && out_free && tail.exp1 && cnt_r != tht_pkg::MAX_RESULTS) begin
      wr.we   = 1'b1;
      wr.kill = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= tht_pkg::TIMEOUT_RESET;
      limit_r     <= tht_pkg::PKT_LIMIT_RESET;
      now_r       <= 32'd0;
      code_r      <= tht_pkg::SEL_NONE;
      cnt_r       <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2]) limit_r <= pwdata[9:0];
        else          timeout_r <= pwdata[15:0];
      end
      if (out_tready && !out_load) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_tuser;
            id_r    <= in_tdata[15:0];
            sip_r   <= in_tdata[47:16];
            dip_r   <= in_tdata[79:48];
            sport_r <= in_tdata[95:80];
            dport_r <= in_tdata[111:96];
            seq_r   <= in_tdata[143:112];
            ack_r   <= in_tdata[175:144];
            flags_r <= in_tdata[181:176];
            plen_r  <= in_tdata[197:182];
            hdr_r   <= in_tdata[204:198];
            fake_r  <= in_tdata[218:205];
            state_r <= (in_tuser == tht_pkg::OP_REGISTER && bad_fake) ? S_BAD : S_CHK;
          end
        end
        S_BAD: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= tht_pkg::KIND_FAIL;
            out_id_r     <= id_r;
            out_reason_r <= tht_pkg::FR_BAD_FAKE;
            out_seq_r    <= 32'd0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_CHK: begin
          cnt_r <= 7'd0;
          priority case (op_r)
            tht_pkg::OP_CANCEL: state_r <= S_IDLE;
            tht_pkg::OP_TICK: begin
              now_r   <= bc.now1;
              code_r  <= tht_pkg::SEL_EXPIRED;
              state_r <= S_EXP;
            end
            default: state_r <= S_PICK;
          endcase
        end
        S_PICK: begin
          // Carries at the tail come from the flags taken in the check cycle.
          if (op_r == tht_pkg::OP_SEGMENT) begin
            code_r  <= tail.hit ? tht_pkg::SEL_HIT : tht_pkg::SEL_NONE;
            state_r <= tail.hit ? S_READ : S_IDLE;
          end else begin
            code_r  <= tail.fd ? tht_pkg::SEL_FREE_DONE :
                       (tail.fr ? tht_pkg::SEL_FREE : tht_pkg::SEL_NONE);
            state_r <= S_READ;
          end
        end
        S_READ: begin
          rd_r    <= rd_tail;
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (out_free) begin
            out_id_r   <= op_r == tht_pkg::OP_REGISTER ? id_r : rd_r.tag;
            out_last_r <= 1'b1;
            if (op_r == tht_pkg::OP_REGISTER) begin
              out_valid_r  <= 1'b1;
              out_kind_r   <= code_r == tht_pkg::SEL_NONE ? tht_pkg::KIND_FAIL
                                                          : tht_pkg::KIND_WATCH;
              out_reason_r <= code_r == tht_pkg::SEL_NONE ? tht_pkg::FR_BUSY
                                                          : tht_pkg::FR_TOO_BIG;
              out_seq_r    <= 32'd0;
            end else begin
              out_valid_r  <= dec_emit;
              out_kind_r   <= dec_kind;
              out_reason_r <= dec_kind == tht_pkg::KIND_FAIL ? dec_reason : tht_pkg::FR_TOO_BIG;
              out_seq_r    <= dec_seq;
            end
            code_r  <= tht_pkg::SEL_NONE;
            state_r <= S_IDLE;
          end
        end
        S_EXP: begin
          // One timeout a cycle while unstalled, first expired slot first, at most 64 a tick.
          if (!tail.exp1 || cnt_r == tht_pkg::MAX_RESULTS) begin
            code_r  <= tht_pkg::SEL_NONE;
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= tht_pkg::KIND_FAIL;
            out_id_r     <= rd_tail.tag;
            out_reason_r <= tht_pkg::FR_TIMEOUT;
            out_seq_r    <= 32'd0;
            out_last_r   <= !tail.exp2 || cnt_r == tht_pkg::MAX_RESULTS - 7'd1;
            cnt_r        <= cnt_r + 7'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/tht_checker.sv
// Port-level checks of the flow tracker and the bind that attaches them.
// Depends on tht_pkg and on tcp_handshake_flow_tracker.
module tht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        pready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item dropped while stalled");

  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != tht_pkg::KIND_FAIL |-> out_tdata[19:16] == 4'd0)
    else $error("failure cause on a non-failure result");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != tht_pkg::KIND_INJECT |-> out_tdata[51:20] == 32'd0)
    else $error("inject sequence on a non-inject result");

  a_reset: assert property (@(posedge clk) rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result valid straight after reset");

  a_ready: assert property (@(posedge clk) pready)
    else $error("register port not ready");

endmodule

bind tcp_handshake_flow_tracker tht_checker u_tht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .pready    (pready)
);

### tb/sv/tb.sv
// Self-checking testbench of the TCP handshake flow tracker.
// Holds its own model of the flow table; depends on tht_pkg and the top level.
module tb;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] flow_id;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [5:0]  flags;
    logic [15:0] payload;
    logic [6:0]  hdr;
    logic [13:0] fake;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [3:0]  reason;
    logic [31:0] seq;
    logic        last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [223:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tcp_handshake_flow_tracker uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the flow table and the registers.
  logic        f_active [SLOTS];
  logic [2:0]  f_phase  [SLOTS];
  logic [15:0] f_tag    [SLOTS];
  logic [31:0] f_lip    [SLOTS];
  logic [31:0] f_rip    [SLOTS];
  logic [15:0] f_lport  [SLOTS];
  logic [15:0] f_rport  [SLOTS];
  logic [13:0] f_fake   [SLOTS];
  logic [31:0] f_syn    [SLOTS];
  logic [31:0] f_synack [SLOTS];
  logic [31:0] f_dead   [SLOTS];
  logic [31:0] now_ticks;
  logic [15:0] timeout_ticks;
  logic [9:0]  packet_limit;

  item_t pending_items[$];
  res_t  expected_results[$];
  int    errors = 0;
  int    cycles = 0;

  // Drive queue state shared with the initial block.
  logic sender_paused = 1'b0;
  logic hold_off_req = 1'b0;

  function automatic void push_result(logic [1:0] k, logic [15:0] id, logic [3:0] r,
                                      logic [31:0] s);
    res_t e;
    e.kind = k; e.id = id; e.reason = r; e.seq = s; e.last = 1'b0;
    expected_results.push_back(e);
  endfunction

  function automatic void close_flow(int i, logic [1:0] k, logic [3:0] r);
    f_phase[i] = tht_pkg::PH_DONE;
    f_active[i] = 1'b0;
    push_result(k, f_tag[i], r, '0);
  endfunction

  function automatic void track_segment(item_t it);
    int hit;
    logic outbound, rst, pure_ack, bare_syn, syn_ack;
    hit = -1;
    outbound = 1'b0;
    rst = it.flags[tht_pkg::FLAG_RST];
    pure_ack = it.flags[tht_pkg::FLAG_ACK] && !it.flags[tht_pkg::FLAG_SYN] && !rst &&
               it.payload == 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (f_active[i] && hit < 0) begin
        if (f_lip[i] == it.src_ip && f_lport[i] == it.sport &&
            f_rip[i] == it.dst_ip && f_rport[i] == it.dport) begin
          hit = i; outbound = 1'b1;
        end else if (f_rip[i] == it.src_ip && f_rport[i] == it.sport &&
                     f_lip[i] == it.dst_ip && f_lport[i] == it.dport) begin
          hit = i;
        end
      end
    end
    if (hit < 0) return;
    if (outbound) begin
      bare_syn = it.flags[tht_pkg::FLAG_SYN] && !it.flags[tht_pkg::FLAG_ACK] &&
                 it.payload == 0 && it.ack_num == 0;
      case (f_phase[hit])
        tht_pkg::PH_WANT_SYN: begin
          if (bare_syn) begin
            f_syn[hit] = it.seq_num; f_phase[hit] = tht_pkg::PH_WANT_SYNACK;
          end else if (rst) close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_RST_PRE_SYNACK);
        end
        tht_pkg::PH_WANT_SYNACK: begin
          if (!(bare_syn && it.seq_num == f_syn[hit]) && rst)
            close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_RST_PRE_SYNACK2);
        end
        tht_pkg::PH_WANT_ACK: begin
          if (pure_ack && it.seq_num == f_syn[hit] + 32'd1 &&
              it.ack_num == f_synack[hit] + 32'd1) begin
            f_phase[hit] = tht_pkg::PH_FAKE_SENT;
            if (32'(it.hdr) + 32'(f_fake[hit]) > 32'(packet_limit))
              close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_TOO_BIG);
            else
              push_result(tht_pkg::KIND_INJECT, f_tag[hit], '0,
                          f_syn[hit] + 32'd1 - 32'(f_fake[hit]));
          end else if (rst) close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_RST_PRE_ACK);
        end
        tht_pkg::PH_FAKE_SENT: begin
          if (it.payload > 0) close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_OUT_AFTER_FAKE);
        end
        default: ;
      endcase
    end else begin
      syn_ack = it.flags[tht_pkg::FLAG_SYN] && it.flags[tht_pkg::FLAG_ACK] && it.payload == 0;
      case (f_phase[hit])
        tht_pkg::PH_WANT_SYN: close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_NO_SYN);
        tht_pkg::PH_WANT_SYNACK: begin
          if (syn_ack) begin
            if (it.ack_num != f_syn[hit] + 32'd1)
              close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_ACK_MISMATCH);
            else if (f_synack[hit] != 0 && f_synack[hit] != it.seq_num)
              close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_SEQ_CHANGE);
            else begin
              f_synack[hit] = it.seq_num; f_phase[hit] = tht_pkg::PH_WANT_ACK;
            end
          end else if (rst) close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_RST_GOT);
          else close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_UNEXP_IN);
        end
        tht_pkg::PH_WANT_ACK: begin
          if (rst) close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_RST_GOT2);
        end
        tht_pkg::PH_FAKE_SENT: begin
          if (pure_ack && it.seq_num == f_synack[hit] + 32'd1 &&
              it.ack_num == f_syn[hit] + 32'd1) close_flow(hit, tht_pkg::KIND_OK, '0);
          else if (rst) close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_RST_AFTER_FAKE);
          else if (it.payload > 0)
            close_flow(hit, tht_pkg::KIND_FAIL, tht_pkg::FR_UNEXP_AFTER_FAKE);
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void track_register(item_t it);
    int pick;
    pick = -1;
    if (it.fake == 0 || it.fake > tht_pkg::FAKE_MAX_BYTES) begin
      push_result(tht_pkg::KIND_FAIL, it.flow_id, tht_pkg::FR_BAD_FAKE, '0);
      return;
    end
    for (int i = 0; i < SLOTS; i++)
      if (pick < 0 && !f_active[i] && f_phase[i] == tht_pkg::PH_DONE) pick = i;
    for (int i = 0; i < SLOTS; i++)
      if (pick < 0 && !f_active[i]) pick = i;
    if (pick < 0) begin
      push_result(tht_pkg::KIND_FAIL, it.flow_id, tht_pkg::FR_BUSY, '0);
      return;
    end
    f_active[pick] = 1'b1; f_phase[pick] = tht_pkg::PH_WANT_SYN; f_tag[pick] = it.flow_id;
    f_lip[pick] = it.src_ip; f_rip[pick] = it.dst_ip;
    f_lport[pick] = it.sport; f_rport[pick] = it.dport;
    f_fake[pick] = it.fake; f_syn[pick] = '0; f_synack[pick] = '0;
    f_dead[pick] = now_ticks + 32'(timeout_ticks);
    push_result(tht_pkg::KIND_WATCH, it.flow_id, '0, '0);
  endfunction

  // Works out the results of one accepted item and queues them in order.
  function automatic void track_item(item_t it);
    int before_n, n;
    logic [31:0] d;
    before_n = expected_results.size();
    case (it.op)
      tht_pkg::OP_SEGMENT:  track_segment(it);
      tht_pkg::OP_REGISTER: track_register(it);
      tht_pkg::OP_CANCEL: begin
        for (int i = 0; i < SLOTS; i++)
          if (f_active[i] && f_tag[i] == it.flow_id) begin
            f_active[i] = 1'b0; f_phase[i] = tht_pkg::PH_DONE;
          end
      end
      default: begin
        now_ticks = now_ticks + 32'd1;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
          d = now_ticks - f_dead[i];
          if (n < 64 && f_active[i] && d != 0 && d < 32'h8000_0000) begin
            close_flow(i, tht_pkg::KIND_FAIL, tht_pkg::FR_TIMEOUT);
            n++;
          end
        end
      end
    endcase
    if (expected_results.size() > before_n)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // Driver: bursts of random length with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        track_item(pending_items.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // Hold the offered item until it is taken.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0 && !sender_paused) begin
        in_tvalid <= 1'b1;
        in_tdata <= {5'd0, pending_items[0].fake, pending_items[0].hdr,
                     pending_items[0].payload, pending_items[0].flags,
                     pending_items[0].ack_num, pending_items[0].seq_num,
                     pending_items[0].dport, pending_items[0].sport,
                     pending_items[0].dst_ip, pending_items[0].src_ip,
                     pending_items[0].flow_id};
        in_tuser <= pending_items[0].op;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request.
  int hold_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_off_req && hold_left == 0) hold_left <= 600;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin
    res_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser; got.id = out_tdata[15:0]; got.reason = out_tdata[19:16];
      got.seq = out_tdata[51:20]; got.last = out_tlast;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors <= errors + 1;
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        if (got.id !== want.id)
          $display("%0t: result_id expected %h actual %h", $time, want.id, got.id);
        if (got.reason !== want.reason)
          $display("%0t: fail_reason expected %0d actual %0d", $time, want.reason, got.reason);
        if (got.seq !== want.seq)
          $display("%0t: inject_seq expected %h actual %h", $time, want.seq, got.seq);
        if (got.last !== want.last)
          $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        if (got !== want) errors <= errors + 1;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Flow addresses used by the random part, a few so that segments find them.
  logic [31:0] pool_lip [8];
  logic [31:0] pool_rip [8];
  logic [15:0] pool_lport [8];
  logic [15:0] pool_rport [8];
  logic [31:0] pool_syn [8];
  logic [31:0] pool_synack [8];
  logic [15:0] pool_tag [8];

  function automatic item_t blank_item(logic [1:0] op);
    item_t it;
    it = '0;
    it.op = op;
    it.hdr = 7'd40;
    return it;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.op = 2'($urandom_range(0, 3));
    it.flow_id = 16'($urandom); it.src_ip = $urandom; it.dst_ip = $urandom;
    it.sport = 16'($urandom); it.dport = 16'($urandom);
    it.seq_num = $urandom; it.ack_num = $urandom; it.flags = 6'($urandom);
    it.payload = 16'($urandom); it.hdr = 7'($urandom_range(40, 120));
    it.fake = 14'($urandom);
    return it;
  endfunction

  // A segment of flow k; dir 1 is local to remote.
  function automatic item_t flow_seg(int k, bit dir, logic [5:0] fl, logic [31:0] sq,
                                     logic [31:0] ak, logic [15:0] pl);
    item_t it;
    it = blank_item(tht_pkg::OP_SEGMENT);
    it.src_ip = dir ? pool_lip[k] : pool_rip[k];
    it.dst_ip = dir ? pool_rip[k] : pool_lip[k];
    it.sport = dir ? pool_lport[k] : pool_rport[k];
    it.dport = dir ? pool_rport[k] : pool_lport[k];
    it.flags = fl; it.seq_num = sq; it.ack_num = ak; it.payload = pl;
    it.hdr = 7'($urandom_range(40, 120));
    return it;
  endfunction

  function automatic item_t flow_reg(int k, logic [13:0] fk);
    item_t it;
    it = blank_item(tht_pkg::OP_REGISTER);
    it.flow_id = pool_tag[k];
    it.src_ip = pool_lip[k]; it.dst_ip = pool_rip[k];
    it.sport = pool_lport[k]; it.dport = pool_rport[k];
    it.fake = fk;
    return it;
  endfunction

  // Queues one well-formed handshake with a random break or ending.
  task automatic queue_handshake(int k);
    int stop;
    logic [13:0] fk;
    stop = $urandom_range(0, 9);
    fk = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(400, 8192))
                                     : 14'($urandom_range(1, 300));
    pool_syn[k] = $urandom; pool_synack[k] = $urandom;
    pending_items.push_back(flow_reg(k, fk));
    if (stop == 0) begin
      pending_items.push_back(flow_seg(k, 1'b0, 6'h10, $urandom, $urandom, 16'd0));
      return;
    end
    pending_items.push_back(flow_seg(k, 1'b1, 6'h02, pool_syn[k], 32'd0, 16'd0));
    if (stop == 1) begin
      pending_items.push_back(flow_seg(k, 1'b0, 6'h12, pool_synack[k], $urandom, 16'd0));
      return;
    end
    if (stop == 2) begin
      pending_items.push_back(flow_seg(k, 1'($urandom_range(0, 1)), 6'h04, $urandom,
                                       32'd0, 16'd0));
      return;
    end
    pending_items.push_back(flow_seg(k, 1'b0, 6'h12, pool_synack[k], pool_syn[k] + 32'd1,
                                     16'd0));
    if (stop == 3) begin
      pending_items.push_back(flow_seg(k, 1'b0, 6'h14, $urandom, 32'd0, 16'd0));
      return;
    end
    pending_items.push_back(flow_seg(k, 1'b1, 6'h10, pool_syn[k] + 32'd1,
                                     pool_synack[k] + 32'd1, 16'd0));
    case (stop)
      4: pending_items.push_back(flow_seg(k, 1'b1, 6'h18, $urandom, 32'd0,
                                          16'($urandom_range(1, 9))));
      5: pending_items.push_back(flow_seg(k, 1'b0, 6'h04, $urandom, 32'd0, 16'd0));
      6: pending_items.push_back(flow_seg(k, 1'b0, 6'h18, $urandom, 32'd0,
                                          16'($urandom_range(1, 99))));
      default: pending_items.push_back(flow_seg(k, 1'b0, 6'h10, pool_synack[k] + 32'd1,
                                                pool_syn[k] + 32'd1, 16'd0));
    endcase
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) timeout_ticks = value[15:0];
    else if (addr == 3'd4) packet_limit = value[9:0];
  endtask

  // Lets the block drain, then waits out a tick's worst latency.
  task automatic drain();
    wait (pending_items.size() == 0 && !in_tvalid && expected_results.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic queue_ticks(int n);
    repeat (n) pending_items.push_back(blank_item(tht_pkg::OP_TICK));
  endtask

  initial begin
    item_t it;
    int pend_mark;
    for (int i = 0; i < SLOTS; i++) begin
      f_active[i] = 1'b0; f_phase[i] = tht_pkg::PH_WANT_SYN; f_tag[i] = '0;
      f_lip[i] = '0; f_rip[i] = '0; f_lport[i] = '0; f_rport[i] = '0; f_fake[i] = '0;
      f_syn[i] = '0; f_synack[i] = '0; f_dead[i] = '0;
    end
    now_ticks = '0; timeout_ticks = tht_pkg::TIMEOUT_RESET;
    packet_limit = tht_pkg::PKT_LIMIT_RESET;
    for (int k = 0; k < 8; k++) begin
      pool_lip[k] = $urandom; pool_rip[k] = $urandom;
      pool_lport[k] = 16'($urandom); pool_rport[k] = 16'($urandom);
      pool_tag[k] = 16'($urandom);
    end
    pool_lip[0] = '0; pool_rip[0] = '1; pool_lport[0] = '0; pool_rport[0] = '1;
    pool_tag[1] = 16'hffff;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: tight limits so that expiry and the size check are reached.
    cfg_write(3'd0, 32'd1);
    cfg_write(3'd4, 32'd40);
    it = flow_reg(0, 14'd0); pending_items.push_back(it);
    it = flow_reg(0, 14'd8193); pending_items.push_back(it);
    it = flow_reg(0, 14'd16383); pending_items.push_back(it);
    pending_items.push_back(flow_reg(0, 14'd1));
    pending_items.push_back(flow_seg(0, 1'b1, 6'h02, 32'hffff_ffff, 32'd0, 16'd0));
    pending_items.push_back(flow_seg(0, 1'b0, 6'h12, 32'h0, 32'h0, 16'd0));
    it = flow_seg(0, 1'b1, 6'h10, 32'd0, 32'd1, 16'd0); it.hdr = 7'd120;
    pending_items.push_back(it);
    pending_items.push_back(flow_reg(1, 14'd8192));
    queue_ticks(3);
    pending_items.push_back(flow_reg(2, 14'd5));
    it = blank_item(tht_pkg::OP_CANCEL); it.flow_id = pool_tag[2]; pending_items.push_back(it);
    pending_items.push_back(flow_seg(2, 1'b1, 6'h3f, '1, '1, 16'hffff));
    drain();

    // Fill the table to reach the busy case, then cancel every flow.
    cfg_write(3'd0, 32'd65535);
    cfg_write(3'd4, 32'd1023);
    for (int i = 0; i < SLOTS + 2; i++) begin
      it = flow_reg(i % 8, 14'($urandom_range(1, 8192)));
      it.sport = 16'(i);
      pending_items.push_back(it);
    end
    // Long receiver hold-off while the sender keeps offering.
    hold_off_req <= 1'b1;
    @(posedge clk);
    hold_off_req <= 1'b0;
    drain();
    cfg_write(3'd0, 32'd2);
    for (int k = 0; k < 8; k++) begin
      it = blank_item(tht_pkg::OP_CANCEL); it.flow_id = pool_tag[k];
      pending_items.push_back(it);
    end
    queue_ticks(2);
    drain();

    // Random part over several register settings.
    for (int phase_n = 0; phase_n < 4; phase_n++) begin
      case (phase_n)
        0: begin cfg_write(3'd0, 32'd8000); cfg_write(3'd4, 32'd512); end
        1: begin cfg_write(3'd0, 32'($urandom_range(1, 6))); cfg_write(3'd4, 32'd200); end
        2: begin cfg_write(3'd0, 32'd65535); cfg_write(3'd4, 32'd1023); end
        default: begin
          cfg_write(3'd0, 32'($urandom_range(1, 65535)));
          cfg_write(3'd4, 32'($urandom_range(40, 1023)));
        end
      endcase
      for (int n = 0; n < 10; n++) begin
        case ($urandom_range(0, 9))
          0, 1: pending_items.push_back(noise_item());
          2: queue_ticks($urandom_range(1, 4));
          default: queue_handshake($urandom_range(0, 7));
        endcase
      end
      // Halfway through, the sender pauses until every expected result has come.
      pend_mark = pending_items.size() / 2;
      wait (pending_items.size() <= pend_mark);
      sender_paused <= 1'b1;
      @(posedge clk);
      wait (!in_tvalid && expected_results.size() == 0);
      sender_paused <= 1'b0;
      drain();
    end

    drain();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
